/* rtl/mgne_pkg.sv */
// ----------------------------------------------------------------------------
// mgne_pkg: shared types and constants for maze graph node extraction
// Field widths, the open-pixel color, node kind codes, register indexes
// and the pending-link entry layout.
// ----------------------------------------------------------------------------
package mgne_pkg;

  // Image size limits and the counter widths that follow from them
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);

  // Fixed field widths
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned ID_W    = 20;
  localparam int unsigned POS_W   = 10;

  localparam logic [COLOR_W-1:0] WHITE_RGB = 24'hFFFFFF;

  typedef enum logic [1:0] {
    KIND_INTERIOR = 2'd0,
    KIND_ENTRANCE = 2'd1,
    KIND_EXIT     = 2'd2
  } node_kind_e;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_e;

  // Pending link to a node waiting for its east or south partner
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } link_entry_t;

  // Open flags of a pixel and its four neighbors
  typedef struct packed {
    logic c;
    logic n;
    logic s;
    logic e;
    logic w;
  } pix_open_t;

  function automatic logic is_open(logic [COLOR_W-1:0] color);
    return color == WHITE_RGB;
  endfunction

  // Holes and straight corridors make no node
  function automatic logic makes_node(logic n, logic s, logic e, logic w);
    logic hole;
    logic ns_corr;
    logic ew_corr;
    hole    = !n && !s && !e && !w;
    ns_corr = n && s && !e && !w;
    ew_corr = !n && !s && e && w;
    return !(hole || ns_corr || ew_corr);
  endfunction

endpackage

/* rtl/maze_graph_node_extraction.sv */
// ----------------------------------------------------------------------------
// maze_graph_node_extraction: raster pixel stream to maze graph nodes
// Each input beat passes the stage 1 register and then the output register.
// Throughput: one pixel per cycle while the input is not stalled, set by the
// read-modify-write of the per-column link table (read port at accept, write
// port when stage 1 retires, same-column hits bypassed). Input stalls only
// while stage 1 and a held result are both full.
// Reset: counters, node id, row skip and links clear asynchronously. The
// column table is not swept: a fill count marks entries not yet touched
// in the current image as empty, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module maze_graph_node_extraction
  import mgne_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  // Pixel input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [COLOR_W-1:0] center_color_i,
  input  logic [COLOR_W-1:0] north_color_i,
  input  logic [COLOR_W-1:0] south_color_i,
  input  logic [COLOR_W-1:0] east_color_i,
  input  logic [COLOR_W-1:0] west_color_i,
  // Node result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               node_valid_o,
  output logic [ID_W-1:0]    node_id_o,
  output logic [POS_W-1:0]   node_x_o,
  output logic [POS_W-1:0]   node_y_o,
  output logic [1:0]         node_kind_o,
  output logic               west_linked_o,
  output logic [ID_W-1:0]    west_node_id_o,
  output logic               north_linked_o,
  output logic [ID_W-1:0]    north_node_id_o,
  output logic               image_done_o
);

  // Configuration registers
  logic [CFG_W-1:0] cfg_width_q, cfg_height_q;
  logic [CFG_W-1:0] eff_width, eff_height;
  logic [CFG_W-1:0] width_last, height_last;

  // Position counters
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             last_col, last_row;

  // Stage 1 registers
  logic             s1_valid_q;
  pix_open_t        s1_open_q;
  logic [COL_W-1:0] s1_x_q;
  logic [ROW_W-1:0] s1_y_q;
  logic             s1_last_col_q, s1_last_row_q;

  // Node state
  logic             row_skip_q, row_skip_d;
  logic [ID_W-1:0]  next_id_q, next_id_d;
  link_entry_t      west_q, west_d;
  logic [COL_W:0]   cover_q;

  // Column table and its read path
  link_entry_t      north_mem [MAX_WIDTH];
  link_entry_t      rd_data_q;
  logic             fwd_q;
  link_entry_t      fwd_data_q;
  link_entry_t      entry_rd, entry_wr;
  logic             north_hit;

  // Stage 1 results
  logic             made;
  node_kind_e       kind;
  logic             wl, nl;
  logic [ID_W-1:0]  node_id, wid, nid;

  // Output register
  logic             out_valid_q;
  logic             out_node_valid_q;
  logic [ID_W-1:0]  out_node_id_q;
  logic [POS_W-1:0] out_x_q, out_y_q;
  node_kind_e       out_kind_q;
  logic             out_wl_q, out_nl_q;
  logic [ID_W-1:0]  out_wid_q, out_nid_q;
  logic             out_done_q;

  // Handshake
  logic             in_acc, s1_fire, out_hold;

  assign out_hold    = out_valid_q && out_stall_i;
  assign s1_fire     = s1_valid_q && !out_hold;
  assign in_stall_o  = s1_valid_q && out_hold;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= CFG_W'(MAX_WIDTH);
      cfg_height_q <= CFG_W'(MAX_HEIGHT);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  cfg_width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: cfg_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the image size to its legal range
  always_comb begin
    if (cfg_width_q < CFG_W'(1)) begin
      eff_width = CFG_W'(1);
    end else if (cfg_width_q > CFG_W'(MAX_WIDTH)) begin
      eff_width = CFG_W'(MAX_WIDTH);
    end else begin
      eff_width = cfg_width_q;
    end
    if (cfg_height_q < CFG_W'(2)) begin
      eff_height = CFG_W'(2);
    end else if (cfg_height_q > CFG_W'(MAX_HEIGHT)) begin
      eff_height = CFG_W'(MAX_HEIGHT);
    end else begin
      eff_height = cfg_height_q;
    end
  end

  assign width_last  = eff_width - CFG_W'(1);
  assign height_last = eff_height - CFG_W'(1);
  assign last_col    = CFG_W'(col_q) >= width_last;
  assign last_row    = CFG_W'(row_q) >= height_last;

  // Advance position and load stage 1 on each input beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_open_q.c   <= is_open(center_color_i);
      s1_open_q.n   <= is_open(north_color_i);
      s1_open_q.s   <= is_open(south_color_i);
      s1_open_q.e   <= is_open(east_color_i);
      s1_open_q.w   <= is_open(west_color_i);
      s1_x_q        <= col_q;
      s1_y_q        <= row_q;
      s1_last_col_q <= last_col;
      s1_last_row_q <= last_row;
    end
  end

  // Column table: read at accept, write back when stage 1 retires
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      north_mem[s1_x_q] <= entry_wr;
    end
    if (in_acc) begin
      rd_data_q <= north_mem[col_q];
    end
  end

  // Forward a write that hits the address being read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc) begin
      fwd_q <= s1_fire && (s1_x_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_data_q <= entry_wr;
    end
  end

  // Decide node creation and links for the pixel in stage 1
  always_comb begin
    entry_rd   = fwd_q ? fwd_data_q : rd_data_q;
    north_hit  = entry_rd.valid && ({1'b0, s1_x_q} < cover_q);
    entry_wr   = '{valid: north_hit, id: entry_rd.id};
    made       = 1'b0;
    kind       = KIND_INTERIOR;
    node_id    = '0;
    wl         = 1'b0;
    nl         = 1'b0;
    wid        = '0;
    nid        = '0;
    next_id_d  = next_id_q;
    row_skip_d = row_skip_q;
    west_d     = west_q;

    if (!row_skip_q && s1_open_q.c) begin
      if (s1_y_q == '0) begin
        made       = 1'b1;
        kind       = KIND_ENTRANCE;
        node_id    = next_id_q;
        entry_wr   = '{valid: 1'b1, id: next_id_q};
        row_skip_d = 1'b1;
      end else if (s1_last_row_q) begin
        made       = 1'b1;
        kind       = KIND_EXIT;
        node_id    = next_id_q;
        row_skip_d = 1'b1;
      end else if (makes_node(s1_open_q.n, s1_open_q.s, s1_open_q.e, s1_open_q.w)) begin
        made    = 1'b1;
        node_id = next_id_q;
        // take the west link
        if (s1_open_q.w && west_q.valid) begin
          wl           = 1'b1;
          wid          = west_q.id;
          west_d.valid = 1'b0;
        end
        // take and drop the north link
        if (s1_open_q.n) begin
          nl             = north_hit;
          nid            = north_hit ? entry_rd.id : '0;
          entry_wr.valid = 1'b0;
        end
        if (s1_open_q.e) begin
          west_d = '{valid: 1'b1, id: next_id_q};
        end
        if (s1_open_q.s) begin
          entry_wr = '{valid: 1'b1, id: next_id_q};
        end
      end
    end

    if (made) begin
      next_id_d = next_id_q + ID_W'(1);
    end

    // drop row state at the end of the row
    if (s1_last_col_q) begin
      west_d.valid = 1'b0;
      row_skip_d   = 1'b0;
    end
  end

  // Update node state as stage 1 retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_skip_q <= 1'b0;
      next_id_q  <= '0;
      west_q     <= '0;
      cover_q    <= '0;
    end else if (s1_fire) begin
      row_skip_q <= row_skip_d;
      next_id_q  <= next_id_d;
      west_q     <= west_d;
      if (s1_last_col_q && s1_last_row_q) begin
        cover_q <= '0;
      end else if ({1'b0, s1_x_q} >= cover_q) begin
        cover_q <= {1'b0, s1_x_q} + (COL_W + 1)'(1);
      end
    end
  end

  // Output register: hold the beat until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_node_valid_q <= made;
      out_node_id_q    <= node_id;
      out_x_q          <= made ? POS_W'(s1_x_q) : '0;
      out_y_q          <= made ? POS_W'(s1_y_q) : '0;
      out_kind_q       <= kind;
      out_wl_q         <= wl;
      out_wid_q        <= wid;
      out_nl_q         <= nl;
      out_nid_q        <= nid;
      out_done_q       <= s1_last_col_q && s1_last_row_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign node_valid_o    = out_node_valid_q;
  assign node_id_o       = out_node_id_q;
  assign node_x_o        = out_x_q;
  assign node_y_o        = out_y_q;
  assign node_kind_o     = out_kind_q;
  assign west_linked_o   = out_wl_q;
  assign west_node_id_o  = out_wid_q;
  assign north_linked_o  = out_nl_q;
  assign north_node_id_o = out_nid_q;
  assign image_done_o    = out_done_q;

  // Input stalls only behind a full stage 1 and a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a held result");

  // Node ids advance by one for each created node
  a_id_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && made) |=> (next_id_q == $past(next_id_q) + ID_W'(1)))
    else $error("node id did not advance");

  // Image end empties the column table
  a_cover_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_col_q && s1_last_row_q) |=> (cover_q == '0))
    else $error("column table not emptied at image end");

  // Fill count never runs past the table
  a_cover_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cover_q <= (COL_W + 1)'(MAX_WIDTH))
    else $error("fill count out of range");

endmodule

/* dv/maze_graph_node_extraction_tb.sv */
// ----------------------------------------------------------------------------
// maze_graph_node_extraction_tb: self-checking bench for maze node extraction
// Streams maze images pixel by pixel, each beat with its four neighbor
// colors. A predictor tracks columns, rows, row skipping and the pending
// west and north links, and every result beat is compared field by field.
// Directed images cover the entrance, exit, hole, corridor and junction
// cases and the size clamps. Random mazes, color noise and size changes in
// the middle of an image follow. Sender gaps and receiver stalls vary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module maze_graph_node_extraction_tb
  import mgne_pkg::*;
();

  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_MAX    = 40;
  localparam int RANDOM_PIXELS = 1400;

  // Receiver stall patterns
  localparam int STALL_NONE    = 0;
  localparam int STALL_SCATTER = 1;
  localparam int STALL_RUNS    = 2;

  localparam logic [COLOR_W-1:0] OPEN = WHITE_RGB;
  localparam logic [COLOR_W-1:0] WALL = '0;

  // One pixel window: center and its four neighbors
  typedef struct packed {
    logic [COLOR_W-1:0] c;
    logic [COLOR_W-1:0] n;
    logic [COLOR_W-1:0] s;
    logic [COLOR_W-1:0] e;
    logic [COLOR_W-1:0] w;
  } pixel_t;

  // One result beat as the block should emit it
  typedef struct packed {
    logic             made;
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    node_kind_e       kind;
    logic             west_linked;
    logic [ID_W-1:0]  west_id;
    logic             north_linked;
    logic [ID_W-1:0]  north_id;
    logic             done;
  } node_rec_t;

  logic               clk_i;
  logic               rst_ni          = 1'b0;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [0:0]         cfg_index_i     = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0]   cfg_data_i      = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic [COLOR_W-1:0] center_color_i  = '0;
  logic [COLOR_W-1:0] north_color_i   = '0;
  logic [COLOR_W-1:0] south_color_i   = '0;
  logic [COLOR_W-1:0] east_color_i    = '0;
  logic [COLOR_W-1:0] west_color_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic               node_valid_o;
  logic [ID_W-1:0]    node_id_o;
  logic [POS_W-1:0]   node_x_o;
  logic [POS_W-1:0]   node_y_o;
  logic [1:0]         node_kind_o;
  logic               west_linked_o;
  logic [ID_W-1:0]    west_node_id_o;
  logic               north_linked_o;
  logic [ID_W-1:0]    north_node_id_o;
  logic               image_done_o;

  maze_graph_node_extraction u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .center_color_i  (center_color_i),
    .north_color_i   (north_color_i),
    .south_color_i   (south_color_i),
    .east_color_i    (east_color_i),
    .west_color_i    (west_color_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .node_valid_o    (node_valid_o),
    .node_id_o       (node_id_o),
    .node_x_o        (node_x_o),
    .node_y_o        (node_y_o),
    .node_kind_o     (node_kind_o),
    .west_linked_o   (west_linked_o),
    .west_node_id_o  (west_node_id_o),
    .north_linked_o  (north_linked_o),
    .north_node_id_o (north_node_id_o),
    .image_done_o    (image_done_o)
  );

  // Predictor state, mirrors the block after reset
  logic [CFG_W-1:0] cfg_width  = CFG_W'(MAX_WIDTH);
  logic [CFG_W-1:0] cfg_height = CFG_W'(MAX_HEIGHT);
  int unsigned      px_col     = 0;
  int unsigned      px_row     = 0;
  logic             skip_rest  = 1'b0;
  logic [ID_W-1:0]  id_next    = '0;
  link_entry_t      west_wait  = '0;
  link_entry_t      north_wait [MAX_WIDTH];

  node_rec_t predicted_nodes [$];

  // Maze canvas for the random images
  logic [COLOR_W-1:0] canvas [];
  int                 canvas_w;
  int                 canvas_h;
  logic [COLOR_W-1:0] rim_color;

  // Run control and statistics
  int stall_mode     = STALL_NONE;
  int stall_run      = 0;
  int gap_max        = 0;
  int burst_left     = 0;
  int cycles         = 0;
  int mismatches     = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int nodes_seen     = 0;
  int west_links     = 0;
  int north_links    = 0;
  int images_done    = 0;
  int size_settings  = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Work out the result of one pixel and advance the predictor
  function automatic node_rec_t extract_node(pixel_t p);
    int unsigned w_eff;
    int unsigned h_eff;
    logic        last_col;
    logic        last_row;
    logic        n_open;
    logic        s_open;
    logic        e_open;
    logic        w_open;
    logic        no_node;
    node_rec_t   r;
    w_eff = (cfg_width < 1) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
    h_eff = (cfg_height < 2) ? 2 : ((cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height);
    last_col = (px_col >= w_eff - 1);
    last_row = (px_row >= h_eff - 1);
    n_open = (p.n == WHITE_RGB);
    s_open = (p.s == WHITE_RGB);
    e_open = (p.e == WHITE_RGB);
    w_open = (p.w == WHITE_RGB);
    // holes and straight corridors make no node
    no_node = (!n_open && !s_open && !e_open && !w_open) ||
              (n_open && s_open && !e_open && !w_open) ||
              (!n_open && !s_open && e_open && w_open);
    r = '0;
    r.kind = KIND_INTERIOR;
    if (!skip_rest && p.c == WHITE_RGB) begin
      if (px_row == 0) begin
        r.made = 1'b1;
        r.kind = KIND_ENTRANCE;
        r.id   = id_next;
        id_next++;
        north_wait[px_col] = '{valid: 1'b1, id: r.id};
        skip_rest = 1'b1;
      end else if (last_row) begin
        r.made = 1'b1;
        r.kind = KIND_EXIT;
        r.id   = id_next;
        id_next++;
        skip_rest = 1'b1;
      end else if (!no_node) begin
        r.made = 1'b1;
        r.id   = id_next;
        id_next++;
        if (w_open && west_wait.valid) begin
          r.west_linked = 1'b1;
          r.west_id     = west_wait.id;
          west_wait.valid = 1'b0;
        end
        if (n_open) begin
          if (north_wait[px_col].valid) begin
            r.north_linked = 1'b1;
            r.north_id     = north_wait[px_col].id;
          end
          north_wait[px_col].valid = 1'b0;
        end
        if (e_open) west_wait = '{valid: 1'b1, id: r.id};
        if (s_open) north_wait[px_col] = '{valid: 1'b1, id: r.id};
      end
    end
    if (r.made) begin
      r.x = POS_W'(px_col);
      r.y = POS_W'(px_row);
    end
    r.done = last_col && last_row;
    // advance the raster position; wrap the table at image end
    if (last_col) begin
      px_col = 0;
      west_wait.valid = 1'b0;
      skip_rest = 1'b0;
      if (last_row) begin
        px_row = 0;
        foreach (north_wait[k]) north_wait[k].valid = 1'b0;
      end else begin
        px_row++;
      end
    end else begin
      px_col++;
    end
    return r;
  endfunction

  function automatic logic [COLOR_W-1:0] wall_color();
    logic [COLOR_W-1:0] c;
    case ($urandom_range(0, 5))
      0: c = WHITE_RGB ^ (COLOR_W'(1) << $urandom_range(0, COLOR_W - 1));
      1: begin
        c = COLOR_W'($urandom());
        if (c == WHITE_RGB) c = '0;
      end
      default: c = WALL;
    endcase
    return c;
  endfunction

  function automatic logic [COLOR_W-1:0] noise_color();
    logic [COLOR_W-1:0] c;
    case ($urandom_range(0, 2))
      0: c = OPEN;
      1: c = wall_color();
      default: c = COLOR_W'($urandom());
    endcase
    return c;
  endfunction

  function automatic logic [COLOR_W-1:0] canvas_at(int x, int y);
    if (x < 0 || y < 0 || x >= canvas_w || y >= canvas_h) return rim_color;
    return canvas[y * canvas_w + x];
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  // Send one pixel beat; open a gap at the start of each burst
  task automatic send_pixel(pixel_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    center_color_i <= p.c;
    north_color_i  <= p.n;
    south_color_i  <= p.s;
    east_color_i   <= p.e;
    west_color_i   <= p.w;
    do @(posedge clk_i); while (in_stall_o);
    predicted_nodes.push_back(extract_node(p));
    items_sent++;
  endtask

  task automatic send_noise();
    send_pixel('{noise_color(), noise_color(), noise_color(), noise_color(),
                 noise_color()});
  endtask

  task automatic end_stream();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (predicted_nodes.size() != 0) @(posedge clk_i);
  endtask

  // Write both size registers once the pipe is empty
  task automatic set_image_size(logic [CFG_W-1:0] w_raw, logic [CFG_W-1:0] h_raw);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_IMAGE_WIDTH;
    cfg_data_i  <= w_raw;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_width   = w_raw;
    cfg_index_i <= CFG_IMAGE_HEIGHT;
    cfg_data_i  <= h_raw;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_height  = h_raw;
    cfg_valid_i <= 1'b0;
    size_settings++;
  endtask

  // Pad with noise until the raster position is back at the origin
  task automatic finish_image();
    while (px_col != 0 || px_row != 0) send_noise();
    end_stream();
  endtask

  task automatic pick_idling();
    stall_mode = $urandom_range(STALL_NONE, STALL_RUNS);
    case ($urandom_range(0, 2))
      0: gap_max = 0;
      1: gap_max = 2;
      default: gap_max = 6;
    endcase
  endtask

  // Reset sizes, then clamps at the top of the width register and the bottom of both
  task automatic test_reset_and_clamps();
    stall_mode = STALL_NONE;
    gap_max    = 0;
    send_pixel('{WALL, OPEN, OPEN, OPEN, OPEN});
    send_pixel('{OPEN, WALL, WALL, WALL, WALL});
    send_pixel('{OPEN, OPEN, OPEN, OPEN, OPEN});
    end_stream();
    // 2047 wide clamps to 1024, height 0 clamps to 2
    set_image_size('1, '0);
    send_pixel('{24'hFFFFFE, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000});
    send_pixel('{OPEN, OPEN, OPEN, OPEN, OPEN});
    end_stream();
    // width 0 clamps to 1: the current row ends, the next is the exit row
    set_image_size('0, CFG_W'(1));
    send_pixel('{OPEN, WALL, WALL, WALL, WALL});
    send_pixel('{OPEN, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF});
    end_stream();
  endtask

  // Hand-drawn 4x4 maze: entrance, hole, corridors, junction, corner, exit
  task automatic test_small_maze();
    set_image_size(CFG_W'(4), CFG_W'(4));
    stall_mode = STALL_SCATTER;
    // entrance row
    send_pixel('{WALL, OPEN, OPEN, OPEN, OPEN});
    send_pixel('{OPEN, WALL, WALL, WALL, WALL});
    send_pixel('{OPEN, OPEN, OPEN, OPEN, OPEN});
    send_pixel('{24'hFFFFFE, WALL, WALL, WALL, WALL});
    // hole, node under the entrance, east-west corridor, west link
    send_pixel('{OPEN, WALL, WALL, WALL, WALL});
    send_pixel('{OPEN, OPEN, WALL, OPEN, WALL});
    send_pixel('{OPEN, WALL, WALL, OPEN, OPEN});
    send_pixel('{OPEN, WALL, OPEN, WALL, OPEN});
    // junction, corner, closed, north-south corridor
    send_pixel('{OPEN, OPEN, OPEN, OPEN, OPEN});
    send_pixel('{OPEN, OPEN, WALL, WALL, OPEN});
    send_pixel('{24'hFF00FF, OPEN, OPEN, OPEN, OPEN});
    send_pixel('{OPEN, OPEN, OPEN, WALL, WALL});
    // exit row
    send_pixel('{OPEN, OPEN, OPEN, OPEN, OPEN});
    send_pixel('{OPEN, OPEN, OPEN, OPEN, OPEN});
    send_pixel('{OPEN, OPEN, OPEN, OPEN, OPEN});
    send_pixel('{OPEN, OPEN, OPEN, OPEN, OPEN});
    end_stream();
  endtask

  // One pixel per row: corridor keeps the north link, shrink forces exit
  task automatic test_single_column();
    set_image_size(CFG_W'(1), '1);
    stall_mode = STALL_RUNS;
    gap_max    = 2;
    send_pixel('{OPEN, WALL, OPEN, WALL, WALL});
    send_pixel('{OPEN, OPEN, OPEN, WALL, WALL});
    send_pixel('{OPEN, OPEN, WALL, WALL, WALL});
    send_pixel('{OPEN, WALL, OPEN, OPEN, OPEN});
    end_stream();
    set_image_size(CFG_W'(1), CFG_W'(2));
    send_pixel('{OPEN, OPEN, OPEN, OPEN, OPEN});
    end_stream();
  endtask

  // Fill the canvas; about half the images of 3x3 or more get a closed frame with two openings
  task automatic paint_maze(int w, int h);
    int   open_pct;
    logic framed;
    canvas_w = w;
    canvas_h = h;
    canvas   = new[w * h];
    open_pct = $urandom_range(40, 80);
    framed   = (w >= 3) && (h >= 3) && ($urandom_range(0, 1) == 1);
    rim_color = ($urandom_range(0, 3) == 0) ? OPEN : wall_color();
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        if (framed && (x == 0 || x == w - 1 || y == 0 || y == h - 1)) begin
          canvas[y * w + x] = wall_color();
        end else begin
          canvas[y * w + x] = ($urandom_range(0, 99) < open_pct) ? OPEN : wall_color();
        end
      end
    end
    if (framed) begin
      canvas[$urandom_range(1, w - 2)] = OPEN;
      canvas[(h - 1) * w + $urandom_range(1, w - 2)] = OPEN;
    end
  endtask

  task automatic send_canvas();
    for (int y = 0; y < canvas_h; y++) begin
      for (int x = 0; x < canvas_w; x++) begin
        send_pixel('{canvas_at(x, y), canvas_at(x, y - 1), canvas_at(x, y + 1),
                     canvas_at(x + 1, y), canvas_at(x - 1, y)});
      end
    end
    end_stream();
  endtask

  // Whole random mazes of many shapes, idling changed per image
  task automatic test_random_mazes();
    int               w;
    int               h;
    logic [CFG_W-1:0] w_raw;
    logic [CFG_W-1:0] h_raw;
    while (items_sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 5))
        0: w = 1;
        1: w = 2;
        5: w = $urandom_range(21, 48);
        default: w = $urandom_range(3, 20);
      endcase
      if (w > 20) h = $urandom_range(2, 4);
      else h = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(3, 10);
      w_raw = (w == 1 && $urandom_range(0, 1) == 1) ? '0 : CFG_W'(w);
      h_raw = (h == 2 && $urandom_range(0, 1) == 1) ? CFG_W'($urandom_range(0, 1))
                                                     : CFG_W'(h);
      set_image_size(w_raw, h_raw);
      pick_idling();
      paint_maze(w, h);
      send_canvas();
    end
  endtask

  // Independent colors on every field, white on about a third of them
  task automatic test_color_noise();
    set_image_size(CFG_W'(9), CFG_W'(7));
    stall_mode = STALL_RUNS;
    gap_max    = 3;
    repeat (150) send_noise();
    finish_image();
  endtask

  // Shrink the image mid-image, where the raster position may lie beyond the new size
  task automatic test_shrink_mid_image();
    for (int trial = 0; trial < 3; trial++) begin
      set_image_size(CFG_W'(12), CFG_W'(6));
      pick_idling();
      repeat ($urandom_range(20, 60)) send_noise();
      end_stream();
      case (trial)
        0: set_image_size(CFG_W'($urandom_range(1, 3)), CFG_W'(6));
        1: set_image_size(CFG_W'(12), CFG_W'(1));
        default: set_image_size('0, '0);
      endcase
      finish_image();
    end
  endtask

  // Receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_run   <= 0;
    end else begin
      case (stall_mode)
        STALL_NONE: out_stall_i <= 1'b0;
        STALL_SCATTER: out_stall_i <= ($urandom_range(0, 2) == 0);
        default: begin
          if (stall_run == 0) begin
            out_stall_i <= ~out_stall_i;
            stall_run   <= $urandom_range(0, 9);
          end else begin
            stall_run <= stall_run - 1;
          end
        end
      endcase
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    node_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_nodes.size() == 0) begin
        report_mismatch("result beat with no pixel waiting");
      end else begin
        want = predicted_nodes.pop_front();
        check_field("node_valid", 32'(node_valid_o), 32'(want.made));
        check_field("node_id", 32'(node_id_o), 32'(want.id));
        check_field("node_x", 32'(node_x_o), 32'(want.x));
        check_field("node_y", 32'(node_y_o), 32'(want.y));
        check_field("node_kind", 32'(node_kind_o), 32'(want.kind));
        check_field("west_linked", 32'(west_linked_o), 32'(want.west_linked));
        check_field("west_node_id", 32'(west_node_id_o), 32'(want.west_id));
        check_field("north_linked", 32'(north_linked_o), 32'(want.north_linked));
        check_field("north_node_id", 32'(north_node_id_o), 32'(want.north_id));
        check_field("image_done", 32'(image_done_o), 32'(want.done));
        results_seen++;
        if (want.made) nodes_seen++;
        if (want.west_linked) west_links++;
        if (want.north_linked) north_links++;
        if (want.done) images_done++;
      end
    end
  end

  // Hang guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, predicted_nodes.size());
      $display("FAIL maze_graph_node_extraction");
      $finish;
    end
  end

  initial begin
    foreach (north_wait[k]) north_wait[k] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_and_clamps();
    test_small_maze();
    test_single_column();
    test_random_mazes();
    test_color_noise();
    test_shrink_mid_image();
    wait_drained();
    // let the last table write settle before the verdict
    repeat (4) @(posedge clk_i);
    $display("streamed %0d pixels over %0d size settings, %0d images completed",
             items_sent, size_settings, images_done);
    $display("checked %0d results: %0d nodes, %0d west links, %0d north links",
             results_seen, nodes_seen, west_links, north_links);
    if (mismatches == 0 && predicted_nodes.size() == 0) begin
      $display("PASS maze_graph_node_extraction");
    end else begin
      $display("FAIL maze_graph_node_extraction");
    end
    $finish;
  end

endmodule
